>>> sv/abrf_pkg.sv
// shared constants, types and codes of the alpha blended rectangle fill engine
package abrf_pkg;

   localparam int SCREEN_COLS = 320;
   localparam int SCREEN_ROWS = 240;
   localparam int ROW_STRIDE  = 320;

   localparam int STORE_DEPTH = (SCREEN_ROWS - 1) * ROW_STRIDE + SCREEN_COLS;
   localparam int ADDR_W      = (STORE_DEPTH < 2) ? 1 : $clog2(STORE_DEPTH);

   localparam logic OP_FILL = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_RD,
      ST_MUL,
      ST_DIV,
      ST_WR,
      ST_RSP
   } state_type;

   typedef struct packed {
      logic       load;
      logic [7:0] colour;
      logic [7:0] old;
      logic [7:0] alpha;
   } blend_req_type;

endpackage

>>> sv/alpha_blend_rect_fill_core.sv
// top level of the alpha blended rectangle fill engine with its frame store
//
//   channel   ports                        handshake
//   command   start, busy, req_*           taken when start && !busy
//   result    rsp_valid, rsp_*             one-cycle strobe, cannot be held off
//
// after reset a clearing pass writes zero to all 76800 pixels, one a cycle,
// with busy high throughout.
// a read runs setup and a frame store read, then the result strobe; an off-screen
// read goes from setup to the strobe. a fill runs setup, then per covered pixel a
// read, three passes of the shared blend unit and a write; off-screen, only setup.
// the shared blend unit and the single-port frame store set the per-pixel cost.
module alpha_blend_rect_fill_core import abrf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_operation,
   input  logic [11:0] req_x_pos,
   input  logic [11:0] req_y_pos,
   input  logic [11:0] req_rect_width,
   input  logic [11:0] req_rect_height,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic [7:0]  req_alpha,
   output logic        rsp_valid,
   output logic [7:0]  rsp_pixel_red,
   output logic [7:0]  rsp_pixel_green,
   output logic [7:0]  rsp_pixel_blue,
   output logic        rsp_on_screen
);

   state_type state_ff, state_in;

   logic              op_ff, op_in;
   logic [11:0]       x_ff, x_in;
   logic [11:0]       y_ff, y_in;
   logic [11:0]       w_ff, w_in;
   logic [11:0]       h_ff, h_in;
   logic [7:0]        red_ff, red_in;
   logic [7:0]        green_ff, green_in;
   logic [7:0]        blue_ff, blue_in;
   logic [7:0]        alpha_ff, alpha_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] col_base_ff, col_base_in;
   logic [11:0]       col_ff, col_in;
   logic [11:0]       row_ff, row_in;
   logic [11:0]       x_end_ff, x_end_in;
   logic [11:0]       y_end_ff, y_end_in;
   logic              onscr_ff, onscr_in;
   logic [1:0]        ch_ff, ch_in;
   logic [23:0]       pix_ff, pix_in;

   logic [23:0]       mem [STORE_DEPTH];
   logic [23:0]       rd_data_ff;
   logic              mem_we;
   logic [23:0]       mem_wdata;

   blend_req_type     blend_req;
   logic [7:0]        blend_out;

   logic [12:0]       x_sum;
   logic [12:0]       y_sum;
   logic              corner_on;
   logic [ADDR_W-1:0] start_addr;

   abrf_blend_unit u_blend (
      .clock     (clock),
      .blend_req (blend_req),
      .blend_out (blend_out)
   );

   // frame store, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= mem_wdata;
      end
      rd_data_ff <= mem[addr_ff];
   end

   always_comb begin
      x_sum      = 13'(x_ff) + 13'(w_ff);
      y_sum      = 13'(y_ff) + 13'(h_ff);
      corner_on  = (13'(x_ff) < 13'(SCREEN_COLS)) && (13'(y_ff) < 13'(SCREEN_ROWS));
      start_addr = ADDR_W'(ADDR_W'(y_ff) * ADDR_W'(ROW_STRIDE)) + ADDR_W'(x_ff);
   end

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      w_in        = w_ff;
      h_in        = h_ff;
      red_in      = red_ff;
      green_in    = green_ff;
      blue_in     = blue_ff;
      alpha_in    = alpha_ff;
      addr_in     = addr_ff;
      col_base_in = col_base_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      x_end_in    = x_end_ff;
      y_end_in    = y_end_ff;
      onscr_in    = onscr_ff;
      ch_in       = ch_ff;
      pix_in      = pix_ff;
      mem_we      = 1'b0;
      mem_wdata   = pix_ff;
      rsp_valid   = 1'b0;

      blend_req.load  = 1'b0;
      blend_req.alpha = alpha_ff;
      case (ch_ff)
         CH_RED: begin
            blend_req.colour = red_ff;
            blend_req.old    = rd_data_ff[23:16];
         end
         CH_GREEN: begin
            blend_req.colour = green_ff;
            blend_req.old    = rd_data_ff[15:8];
         end
         default: begin
            blend_req.colour = blue_ff;
            blend_req.old    = rd_data_ff[7:0];
         end
      endcase

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = '0;
            addr_in   = addr_ff + ADDR_W'(1);
            if (addr_ff == ADDR_W'(STORE_DEPTH - 1)) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               op_in    = req_operation;
               x_in     = req_x_pos;
               y_in     = req_y_pos;
               w_in     = req_rect_width;
               h_in     = req_rect_height;
               red_in   = req_red;
               green_in = req_green;
               blue_in  = req_blue;
               alpha_in = req_alpha;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            onscr_in    = corner_on;
            addr_in     = start_addr;
            col_base_in = start_addr;
            col_in      = x_ff;
            row_in      = y_ff;
            x_end_in    = (x_sum > 13'(SCREEN_COLS - 1)) ? 12'(SCREEN_COLS - 1) : x_sum[11:0];
            y_end_in    = (y_sum > 13'(SCREEN_ROWS - 1)) ? 12'(SCREEN_ROWS - 1) : y_sum[11:0];
            ch_in       = CH_RED;
            if (!corner_on) begin
               state_in = (op_ff == OP_READ) ? ST_RSP : ST_IDLE;
            end else begin
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            ch_in    = CH_RED;
            state_in = (op_ff == OP_READ) ? ST_RSP : ST_MUL;
         end
         ST_MUL: begin
            blend_req.load = 1'b1;
            state_in       = ST_DIV;
         end
         ST_DIV: begin
            case (ch_ff)
               CH_RED:   pix_in[23:16] = blend_out;
               CH_GREEN: pix_in[15:8]  = blend_out;
               default:  pix_in[7:0]   = blend_out;
            endcase
            if (ch_ff == CH_BLUE) begin
               state_in = ST_WR;
            end else begin
               ch_in    = ch_ff + 2'd1;
               state_in = ST_MUL;
            end
         end
         ST_WR: begin
            mem_we   = 1'b1;
            state_in = ST_RD;
            // column by column, top to bottom within a column
            if (row_ff == y_end_ff) begin
               if (col_ff == x_end_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  col_in      = col_ff + 12'd1;
                  row_in      = y_ff;
                  col_base_in = col_base_ff + ADDR_W'(1);
                  addr_in     = col_base_ff + ADDR_W'(1);
               end
            end else begin
               row_in  = row_ff + 12'd1;
               addr_in = addr_ff + ADDR_W'(ROW_STRIDE);
            end
         end
         ST_RSP: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
      end
      op_ff       <= op_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      w_ff        <= w_in;
      h_ff        <= h_in;
      red_ff      <= red_in;
      green_ff    <= green_in;
      blue_ff     <= blue_in;
      alpha_ff    <= alpha_in;
      col_base_ff <= col_base_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      x_end_ff    <= x_end_in;
      y_end_ff    <= y_end_in;
      onscr_ff    <= onscr_in;
      ch_ff       <= ch_in;
      pix_ff      <= pix_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_on_screen   = onscr_ff;
   assign rsp_pixel_red   = onscr_ff ? rd_data_ff[23:16] : 8'd0;
   assign rsp_pixel_green = onscr_ff ? rd_data_ff[15:8]  : 8'd0;
   assign rsp_pixel_blue  = onscr_ff ? rd_data_ff[7:0]   : 8'd0;

   a_rsp_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_no_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("result strobe right after an accepted item");

   a_write_in_rect: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR) |-> (col_ff <= x_end_ff) && (row_ff <= y_end_ff)
         && (col_ff < 12'(SCREEN_COLS)) && (row_ff < 12'(SCREEN_ROWS)))
      else $error("pixel write outside the clipped rectangle");

   a_rsp_only_for_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (op_ff == OP_READ))
      else $error("result strobe for a fill item");

endmodule

>>> sv/abrf_blend_unit.sv
// shared per-channel blend unit: registered multiply-add, then divide by 255
module abrf_blend_unit import abrf_pkg::*; (
   input  logic          clock,
   input  blend_req_type blend_req,
   output logic [7:0]    blend_out
);

   logic [15:0] num_ff;
   logic [15:0] num_in;
   logic [16:0] sum;
   logic [15:0] prod_new;
   logic [15:0] prod_old;
   logic [16:0] div_sum;

   always_comb begin
      prod_new = 16'(blend_req.colour) * 16'(blend_req.alpha);
      prod_old = 16'(blend_req.old) * 16'(8'd255 - blend_req.alpha);
      sum      = 17'(prod_new) + 17'(prod_old);
      num_in   = blend_req.load ? sum[15:0] : num_ff;
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
   end

   // exact floor(n / 255) for n up to 255 * 255
   always_comb begin
      div_sum   = 17'(num_ff) + 17'(num_ff[15:8]) + 17'd1;
      blend_out = div_sum[15:8];
   end

endmodule

>>> bench/abrf_checker.sv
// checker for the rectangle fill engine: frame store predictor and read result compare
module abrf_checker import abrf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_operation,
   input  logic [11:0] req_x_pos,
   input  logic [11:0] req_y_pos,
   input  logic [11:0] req_rect_width,
   input  logic [11:0] req_rect_height,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic [7:0]  req_alpha,
   input  logic        rsp_valid,
   input  logic [7:0]  rsp_pixel_red,
   input  logic [7:0]  rsp_pixel_green,
   input  logic [7:0]  rsp_pixel_blue,
   input  logic        rsp_on_screen,
   output int          fail_count,
   output int          reads_pending
);

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       on_screen;
   } pixel_read_type;

   logic [23:0]    shadow_frame [STORE_DEPTH];
   pixel_read_type expected_reads [$];
   int             fails;

   function automatic int unsigned store_index(int unsigned col, int unsigned row);
      int unsigned addr;
      addr = row * ROW_STRIDE + col;
      return (addr < STORE_DEPTH) ? addr : 0;
   endfunction

   function automatic logic [7:0] mix_channel(logic [7:0] prev, logic [7:0] colour,
                                              logic [7:0] alpha);
      int unsigned c;
      int unsigned a;
      int unsigned p;
      int unsigned sum;
      c = colour;
      a = alpha;
      p = prev;
      sum = c * a + p * (255 - a);
      return 8'(sum / 255);
   endfunction

   // column by column, top to bottom, so shared addresses blend in visit order
   function automatic void blend_rect(int unsigned x, int unsigned y, int unsigned w,
                                      int unsigned h, logic [7:0] r, logic [7:0] g,
                                      logic [7:0] b, logic [7:0] a);
      int unsigned x_last;
      int unsigned y_last;
      int unsigned idx;
      logic [23:0] prev;
      if (x >= SCREEN_COLS || y >= SCREEN_ROWS) return;
      x_last = (x + w > SCREEN_COLS - 1) ? SCREEN_COLS - 1 : x + w;
      y_last = (y + h > SCREEN_ROWS - 1) ? SCREEN_ROWS - 1 : y + h;
      for (int unsigned col = x; col <= x_last; col++) begin
         for (int unsigned row = y; row <= y_last; row++) begin
            idx  = store_index(col, row);
            prev = shadow_frame[idx];
            shadow_frame[idx] = {mix_channel(prev[23:16], r, a),
                                 mix_channel(prev[15:8], g, a),
                                 mix_channel(prev[7:0], b, a)};
         end
      end
   endfunction

   function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: pixel read %s mismatch, expected %h, actual %h",
                  $time, name, want, got);
         fails++;
      end
   endfunction

   always @(posedge clock) begin
      pixel_read_type want;
      logic [23:0]    stored;
      if (reset) begin
         for (int i = 0; i < STORE_DEPTH; i++) shadow_frame[i] = '0;
         expected_reads.delete();
         fails = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_reads.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h %h %h %b",
                        $time, rsp_pixel_red, rsp_pixel_green, rsp_pixel_blue,
                        rsp_on_screen);
               fails++;
            end else begin
               want = expected_reads.pop_front();
               compare_field("red", want.red, rsp_pixel_red);
               compare_field("green", want.green, rsp_pixel_green);
               compare_field("blue", want.blue, rsp_pixel_blue);
               compare_field("on_screen", {7'd0, want.on_screen}, {7'd0, rsp_on_screen});
            end
         end
         if (start && !busy) begin
            if (req_operation == OP_READ) begin
               if (req_x_pos < SCREEN_COLS && req_y_pos < SCREEN_ROWS) begin
                  stored = shadow_frame[store_index(req_x_pos, req_y_pos)];
                  want   = {stored, 1'b1};
               end else begin
                  want = '0;
               end
               expected_reads.push_back(want);
            end else begin
               blend_rect(req_x_pos, req_y_pos, req_rect_width, req_rect_height,
                          req_red, req_green, req_blue, req_alpha);
            end
         end
      end
      fail_count    <= fails;
      reads_pending <= expected_reads.size();
   end

endmodule

>>> bench/tb_alpha_blend_rect_fill_core.sv
// testbench top for the rectangle fill engine: command stimulus and final verdict
module tb_alpha_blend_rect_fill_core;
   import abrf_pkg::*;

   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int RANDOM_ITEMS = 76;
   localparam int QUIET_ITEMS = 15;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_operation = OP_FILL;
   logic [11:0] req_x_pos = '0;
   logic [11:0] req_y_pos = '0;
   logic [11:0] req_rect_width = '0;
   logic [11:0] req_rect_height = '0;
   logic [7:0]  req_red = '0;
   logic [7:0]  req_green = '0;
   logic [7:0]  req_blue = '0;
   logic [7:0]  req_alpha = '0;
   logic        rsp_valid;
   logic [7:0]  rsp_pixel_red;
   logic [7:0]  rsp_pixel_green;
   logic [7:0]  rsp_pixel_blue;
   logic        rsp_on_screen;
   int          fail_count;
   int          reads_pending;
   bit          quiet = 1'b0;

   always #10 clock = ~clock;

   alpha_blend_rect_fill_core dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_x_pos       (req_x_pos),
      .req_y_pos       (req_y_pos),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_alpha       (req_alpha),
      .rsp_valid       (rsp_valid),
      .rsp_pixel_red   (rsp_pixel_red),
      .rsp_pixel_green (rsp_pixel_green),
      .rsp_pixel_blue  (rsp_pixel_blue),
      .rsp_on_screen   (rsp_on_screen)
   );

   abrf_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_x_pos       (req_x_pos),
      .req_y_pos       (req_y_pos),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_alpha       (req_alpha),
      .rsp_valid       (rsp_valid),
      .rsp_pixel_red   (rsp_pixel_red),
      .rsp_pixel_green (rsp_pixel_green),
      .rsp_pixel_blue  (rsp_pixel_blue),
      .rsp_on_screen   (rsp_on_screen),
      .fail_count      (fail_count),
      .reads_pending   (reads_pending)
   );

   // called at a rising edge; returns at the edge that takes the item
   task automatic issue_command(logic op, int unsigned x, int unsigned y,
                                int unsigned w, int unsigned h, int unsigned r,
                                int unsigned g, int unsigned b, int unsigned a);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_operation   <= op;
      req_x_pos       <= 12'(x);
      req_y_pos       <= 12'(y);
      req_rect_width  <= 12'(w);
      req_rect_height <= 12'(h);
      req_red         <= 8'(r);
      req_green       <= 8'(g);
      req_blue        <= 8'(b);
      req_alpha       <= 8'(a);
      start           <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic read_pixel(int unsigned x, int unsigned y);
      issue_command(OP_READ, x, y, $urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255));
   endtask

   function automatic int unsigned pick_alpha();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 255;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // cleared store, screen corners and off-screen reads
      read_pixel(0, 0);
      read_pixel(319, 239);
      read_pixel(320, 0);
      read_pixel(0, 240);
      read_pixel(4095, 4095);
      // fills with the corner off-screen change nothing
      issue_command(OP_FILL, 320, 0, 5, 5, 'hff, 'hff, 'hff, 'hff);
      issue_command(OP_FILL, 0, 4095, 4095, 4095, 'hff, 'hff, 'hff, 'hff);
      read_pixel(0, 0);
      // whole screen blend, clipped from the largest sizes
      issue_command(OP_FILL, 0, 0, 4095, 4095, 'hff, 'h00, 'haa, 'h80);
      read_pixel(0, 0);
      read_pixel(319, 239);
      read_pixel(160, 120);
      // single pixel full replace, then a no-op alpha over a two by two square
      issue_command(OP_FILL, 2, 3, 0, 0, 'hff, 'hff, 'hff, 'hff);
      issue_command(OP_FILL, 2, 3, 1, 1, 'h00, 'h00, 'h00, 'h00);
      read_pixel(2, 3);
      read_pixel(3, 4);
      // clipped on both edges down to one pixel
      issue_command(OP_FILL, 319, 239, 4095, 4095, 'h55, 'h55, 'h55, 'h01);
      read_pixel(319, 239);
      // clipped at the right edge, then at the bottom edge
      issue_command(OP_FILL, 300, 10, 4095, 2, 'h12, 'hed, 'h7f, 200);
      read_pixel(319, 12);
      issue_command(OP_FILL, 10, 230, 3, 4095, 'hc3, 'h3c, 'h01, 77);
      read_pixel(13, 239);
      issue_command(OP_FILL, 0, 0, 0, 0, 'h00, 'h55, 'haa, 'hff);
      read_pixel(0, 0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         int pick;
         pick  = $urandom_range(0, 99);
         quiet = (n >= RANDOM_ITEMS - QUIET_ITEMS);
         if (pick < 45) begin
            // small blends over a busy corner so reads land on written pixels
            issue_command(OP_FILL, $urandom_range(0, 23), $urandom_range(0, 23),
                          $urandom_range(0, 7), $urandom_range(0, 7),
                          $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255), pick_alpha());
         end else if (pick < 50) begin
            issue_command(OP_FILL, 319 - $urandom_range(0, 5), $urandom_range(0, 239),
                          $urandom_range(0, 4095), $urandom_range(0, 7),
                          $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255), pick_alpha());
         end else if (pick < 55) begin
            issue_command(OP_FILL, $urandom_range(0, 319), 239 - $urandom_range(0, 5),
                          $urandom_range(0, 7), $urandom_range(0, 4095),
                          $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255), pick_alpha());
         end else if (pick < 60) begin
            if ($urandom_range(0, 1))
               issue_command(OP_FILL, $urandom_range(320, 4095), $urandom_range(0, 4095),
                             $urandom_range(0, 4095), $urandom_range(0, 4095),
                             $urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255), pick_alpha());
            else
               issue_command(OP_FILL, $urandom_range(0, 4095), $urandom_range(240, 4095),
                             $urandom_range(0, 4095), $urandom_range(0, 4095),
                             $urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255), pick_alpha());
         end else if (pick < 85) begin
            read_pixel($urandom_range(0, 31), $urandom_range(0, 31));
         end else if (pick < 92) begin
            read_pixel(319 - $urandom_range(0, 5), $urandom_range(0, 239));
         end else begin
            read_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (reads_pending != 0) @(posedge clock);
      while (busy) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && reads_pending == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #(CYCLE_LIMIT * 20);
      $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> filelist.f
sv/abrf_pkg.sv
sv/abrf_blend_unit.sv
sv/alpha_blend_rect_fill_core.sv
bench/abrf_checker.sv
bench/tb_alpha_blend_rect_fill_core.sv
